FILE: sv/interp_table_correction_defines.svh
// Assertion macros for the interpolating table correction block.
`ifndef INTERP_TABLE_CORRECTION_DEFINES_SVH
`define INTERP_TABLE_CORRECTION_DEFINES_SVH
`ifndef SYNTH
`define ITC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ITC_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ITC_ASSERT(lbl, clk, rst, prop, msg)
`define ITC_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: sv/itc_pkg.sv
// Types, codes and helpers shared by the table correction block.
package itc_pkg;

  localparam int DIV_W      = 64;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_SCAN    = 4'd1;
  localparam logic [3:0] OP_RD_LO   = 4'd2;
  localparam logic [3:0] OP_RD_HI   = 4'd3;
  localparam logic [3:0] OP_FRAC    = 4'd4;
  localparam logic [3:0] OP_MUL_V   = 4'd5;
  localparam logic [3:0] OP_MUL_E   = 4'd6;
  localparam logic [3:0] OP_FAC_E   = 4'd7;
  localparam logic [3:0] OP_EDGE    = 4'd8;
  localparam logic [3:0] OP_APPLY_V = 4'd9;
  localparam logic [3:0] OP_TAKE_V  = 4'd10;
  localparam logic [3:0] OP_APPLY_E = 4'd11;
  localparam logic [3:0] OP_TAKE_E  = 4'd12;
  localparam logic [3:0] OP_OUT     = 4'd13;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         entry_slot;
    logic [31:0]        x_position;
    logic [31:0]        x_upper_edge;
    logic signed [31:0] value_in;
    logic signed [31:0] error_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic signed [31:0] error_out;
    logic [31:0]        x_out;
    logic [31:0]        x_upper_out;
    logic               zero_divisor;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [3:0] op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_stop;
    logic edge_case;
    logic div_done;
    logic divide_mode;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  function automatic clamp_t clamp32(input logic signed [63:0] v);
    clamp_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > 64'sh000000007FFFFFFF) begin
      r.sat = 1'b1;
      r.val = 32'h7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      r.sat = 1'b1;
      r.val = 32'h80000000;
    end
    return r;
  endfunction

endpackage

FILE: sv/itc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module itc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [itc_pkg::DIV_W-1:0] dividend,
  input  logic [itc_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [itc_pkg::DIV_W-1:0] quotient
);
  import itc_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [DIV_W:0]   shifted;
  logic             fits;

  assign shifted = {rem[DIV_W-1:0], quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (run) begin
      rem      <= fits ? shifted - {1'b0, dsr} : shifted;
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

FILE: sv/itc_ctrl.sv
// Sequencer for one correction: scan, fetch, interpolate, apply, emit.
module itc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 cmd,
  input  itc_pkg::dp_status_t  status,
  output itc_pkg::ctrl_cmd_t   ctrl,
  output logic                 busy
);
  import itc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_RDLO = 4'd2;
  localparam logic [3:0] S_RDHI = 4'd3;
  localparam logic [3:0] S_FRAC = 4'd4;
  localparam logic [3:0] S_FWAIT = 4'd5;
  localparam logic [3:0] S_MULV = 4'd6;
  localparam logic [3:0] S_MULE = 4'd7;
  localparam logic [3:0] S_FACE = 4'd8;
  localparam logic [3:0] S_EDGE = 4'd9;
  localparam logic [3:0] S_AV   = 4'd10;
  localparam logic [3:0] S_AVW  = 4'd11;
  localparam logic [3:0] S_AE   = 4'd12;
  localparam logic [3:0] S_AEW  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state, state_next;
  logic       result_ready;

  assign busy = state != S_IDLE;
  // in multiply mode the product is ready in the cycle after the apply step
  assign result_ready = !status.divide_mode || status.div_done;

  always_comb begin
    state_next = state;
    ctrl.op    = OP_NONE;
    case (state)
      S_IDLE: if (start && cmd == CMD_CORRECT) state_next = S_SCAN;
      S_SCAN: begin
        ctrl.op = OP_SCAN;
        if (status.scan_stop) state_next = S_RDLO;
      end
      S_RDLO: begin
        ctrl.op    = OP_RD_LO;
        state_next = status.edge_case ? S_EDGE : S_RDHI;
      end
      S_RDHI: begin
        ctrl.op    = OP_RD_HI;
        state_next = S_FRAC;
      end
      S_FRAC: begin
        ctrl.op    = OP_FRAC;
        state_next = S_FWAIT;
      end
      S_FWAIT: if (status.div_done) state_next = S_MULV;
      S_MULV: begin
        ctrl.op    = OP_MUL_V;
        state_next = S_MULE;
      end
      S_MULE: begin
        ctrl.op    = OP_MUL_E;
        state_next = S_FACE;
      end
      S_FACE: begin
        ctrl.op    = OP_FAC_E;
        state_next = S_AV;
      end
      S_EDGE: begin
        ctrl.op    = OP_EDGE;
        state_next = S_AV;
      end
      S_AV: begin
        ctrl.op    = OP_APPLY_V;
        state_next = S_AVW;
      end
      S_AVW: if (result_ready) begin
        ctrl.op    = OP_TAKE_V;
        state_next = S_AE;
      end
      S_AE: begin
        ctrl.op    = OP_APPLY_E;
        state_next = S_AEW;
      end
      S_AEW: if (result_ready) begin
        ctrl.op    = OP_TAKE_E;
        state_next = S_OUT;
      end
      S_OUT: begin
        ctrl.op    = OP_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

FILE: sv/itc_dpath.sv
// Table memories, configuration, search, interpolation and apply datapath.
module itc_dpath #(
  parameter int TABLE_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  itc_pkg::item_t                    item,
  input  logic                              cfg_write,
  input  logic [itc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [itc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  itc_pkg::ctrl_cmd_t                ctrl,
  output itc_pkg::dp_status_t               status,
  output itc_pkg::result_t                  result,
  output logic                              done
);
  import itc_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = IDX_W + 8;

  logic [31:0] mem_x [TABLE_DEPTH];
  logic [31:0] mem_v [TABLE_DEPTH];
  logic [31:0] mem_e [TABLE_DEPTH];

  logic                  divide_mode, hist_mode;
  logic [CFG_DATA_W-1:0] tcount;
  item_t                 cur;
  logic [32:0]           pos;
  logic [CNT_W-1:0]      n, addr, rd_i, found_i, lo_i;
  logic [31:0]           rd_x, prev_x;
  logic                  rd_vld;
  logic                  hit_c, end_c, stop;
  logic [IDX_W-1:0]      f_addr;
  logic [31:0]           rdv, rde;
  logic signed [31:0]    vlo, elo, vhi, ehi, vf, ef;
  logic [FRAC_BITS:0]    frac;
  logic signed [63:0]    prod;
  logic signed [31:0]    res_v;
  logic                  sat_r, zd_r;
  logic [SW-1:0]         slot_w;
  logic [31:0]           tc32;

  // divider
  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_a, div_b, quot;
  logic [32:0]           num, den;

  // apply
  logic                  take_v;
  logic signed [31:0]    dsel, fsel;
  logic [63:0]           dmag;
  logic signed [63:0]    qs, prod_sh;
  clamp_t                cl;
  logic [31:0]           take_val;
  logic                  take_sat, take_zd;

  // interpolation product
  logic signed [32:0]          dfac;
  logic signed [FRAC_BITS+1:0] fs;
  logic signed [FRAC_BITS+34:0] iprod;

  assign slot_w = SW'(item.entry_slot);
  assign tc32   = 32'(tcount);

  always_comb begin
    if (tcount == '0)                           n = CNT_W'(1);
    else if (tc32 > 32'(TABLE_DEPTH))           n = CNT_W'(TABLE_DEPTH);
    else                                        n = CNT_W'(tc32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_mode <= 1'b1;
      hist_mode   <= 1'b0;
      tcount      <= CFG_DATA_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIVIDE: divide_mode <= cfg_data[0];
        CFG_HIST:   hist_mode   <= cfg_data[0];
        CFG_COUNT:  tcount      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_LOAD && slot_w < SW'(TABLE_DEPTH)) begin
      mem_x[slot_w[IDX_W-1:0]] <= item.x_position;
      mem_v[slot_w[IDX_W-1:0]] <= item.value_in;
      mem_e[slot_w[IDX_W-1:0]] <= item.error_in;
    end
  end

  // search: stop at the first entry with 2*x >= pos, or at entry n-1
  assign hit_c = {rd_x, 1'b0} >= pos;
  assign end_c = rd_i == n - 1'b1;
  assign stop  = rd_vld && (hit_c || end_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (accept) begin
      rd_vld <= 1'b0;
    end else if (ctrl.op == OP_SCAN && !stop) begin
      rd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= item;
      addr <= '0;
      pos  <= hist_mode ? {1'b0, item.x_position} + {1'b0, item.x_upper_edge}
                        : {item.x_position, 1'b0};
    end else if (ctrl.op == OP_SCAN) begin
      if (stop) begin
        found_i <= hit_c ? rd_i : n;
      end else begin
        rd_x   <= mem_x[addr[IDX_W-1:0]];
        rd_i   <= addr;
        addr   <= addr + 1'b1;
        prev_x <= rd_x;
      end
    end
  end

  assign lo_i   = (found_i == '0) ? '0 : found_i - 1'b1;
  assign f_addr = (ctrl.op == OP_RD_LO) ? lo_i[IDX_W-1:0] : found_i[IDX_W-1:0];

  always_ff @(posedge clk) begin
    rdv <= mem_v[f_addr];
    rde <= mem_e[f_addr];
  end

  assign num = pos - {prev_x, 1'b0};
  assign den = {rd_x, 1'b0} - {prev_x, 1'b0};

  // operand for the apply steps
  assign take_v = ctrl.op == OP_APPLY_V || ctrl.op == OP_TAKE_V;
  assign dsel   = take_v ? cur.value_in : cur.error_in;
  assign fsel   = take_v ? vf : ef;
  assign dmag   = dsel[31] ? 64'(-65'(dsel)) : 64'(dsel);

  always_comb begin
    div_start = 1'b0;
    div_a     = 64'(num) << FRAC_BITS;
    div_b     = 64'(den);
    if (ctrl.op == OP_FRAC) begin
      div_start = 1'b1;
    end else if ((ctrl.op == OP_APPLY_V || ctrl.op == OP_APPLY_E) && divide_mode) begin
      div_start = 1'b1;
      div_a     = dmag << FRAC_BITS;
      div_b     = fsel[31] ? 64'(-65'(fsel)) : 64'(fsel);
    end
  end

  itc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quot)
  );

  // truncation toward zero: divide magnitudes, then restore the sign
  assign qs      = (dsel[31] ^ fsel[31]) ? -$signed(quot) : $signed(quot);
  assign prod_sh = prod >>> FRAC_BITS;
  assign cl      = clamp32(divide_mode ? qs : prod_sh);

  always_comb begin
    take_val = cl.val;
    take_sat = cl.sat;
    take_zd  = 1'b0;
    if (divide_mode && fsel == '0) begin
      take_zd  = 1'b1;
      take_sat = dsel != '0;
      if (dsel > 0)      take_val = 32'h7FFFFFFF;
      else if (dsel < 0) take_val = 32'h80000000;
      else               take_val = '0;
    end
  end

  always_comb begin
    if (ctrl.op == OP_MUL_V) begin
      dfac = 33'(vhi) - 33'(vlo);
      fs   = $signed({1'b0, quot[FRAC_BITS:0]});
    end else begin
      dfac = 33'(ehi) - 33'(elo);
      fs   = $signed({1'b0, frac});
    end
  end
  assign iprod = dfac * fs;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_RD_HI: begin
        vlo <= rdv;
        elo <= rde;
      end
      OP_FRAC: begin
        vhi <= rdv;
        ehi <= rde;
      end
      OP_MUL_V: begin
        frac <= quot[FRAC_BITS:0];
        prod <= 64'(iprod);
      end
      OP_MUL_E: begin
        vf   <= 32'(64'(vlo) + prod_sh);
        prod <= 64'(iprod);
      end
      OP_FAC_E: ef <= 32'(64'(elo) + prod_sh);
      OP_EDGE: begin
        vf <= rdv;
        ef <= rde;
      end
      OP_APPLY_V, OP_APPLY_E: prod <= dsel * fsel;
      OP_TAKE_V: res_v <= take_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sat_r <= 1'b0;
      zd_r  <= 1'b0;
    end else if (ctrl.op == OP_TAKE_V || ctrl.op == OP_TAKE_E) begin
      sat_r <= sat_r | take_sat;
      zd_r  <= zd_r | take_zd;
    end
    if (ctrl.op == OP_TAKE_E) result.error_out <= take_val;
    if (ctrl.op == OP_OUT) begin
      result.value_out    <= res_v;
      result.x_out        <= cur.x_position;
      result.x_upper_out  <= cur.x_upper_edge;
      result.zero_divisor <= zd_r;
      result.saturated    <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ctrl.op == OP_OUT;
  end

  assign status.scan_stop   = stop;
  assign status.edge_case   = found_i == '0 || found_i == n;
  assign status.div_done    = div_done;
  assign status.divide_mode = divide_mode;

endmodule

FILE: sv/interp_table_correction.sv
// Interpolating correction table: top level joining sequencer and datapath.
//
// Load items (cmd 0) write one table entry at the accept edge and leave busy
// low, so loads can go every cycle. A correct item (cmd 1) holds busy while a
// linear scan reads one table x per cycle until it stops. An interior position
// then fetches both neighbours and runs the 64-step serial divide for the
// interpolation fraction; a position at or past either end of the table takes
// the value of that end entry as it is. Applying both factors takes one multiply
// each in multiply mode, or one serial divide each in divide mode. The result
// shows for one cycle with done high, in the first cycle with busy low again;
// the receiver must take it then, as there is no stall.
module interp_table_correction #(
  parameter int TABLE_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  itc_pkg::item_t                 item,
  output logic                           done,
  output itc_pkg::result_t               result,
  input  logic                           cfg_write,
  input  logic [itc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import itc_pkg::*;

  `include "interp_table_correction_defines.svh"

  ctrl_cmd_t  ctrl;
  dp_status_t status;
  logic       accept;

  assign accept = start && !busy;

  itc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (item.cmd),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  itc_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .status    (status),
    .result    (result),
    .done      (done)
  );

  `ITC_ASSERT(a_done_after_work, clk, rst, done |-> $past(busy), "result beat without work")
  `ITC_ASSERT(a_done_single, clk, rst, done |=> !done, "result beat repeated")
  `ITC_ASSERT(a_load_no_busy, clk, rst, (accept && item.cmd == CMD_LOAD) |=> !busy, "load made busy")
  `ITC_NEVER(a_zd_mult, clk, rst, done && result.zero_divisor && !status.divide_mode, "zero divisor in multiply mode")

endmodule
